// ----- rtl/esrt_pkg.sv -----
package esrt_pkg;

  // field widths
  localparam int TIME_W   = 63;
  localparam int MEM_W    = 64;
  localparam int STAMP_W  = 16;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 40;

  // all-ones start time marks a slot that no stamp owns yet
  localparam logic [MEM_W-1:0]  FROZEN_PAD_UNUSED_NEVER = '0;
  localparam logic [MEM_W-1:0]  FUTURE_TIME   = {MEM_W{1'b1}};
  localparam logic [TIME_W-1:0] FROZEN_RESET  = TIME_W'(1000000);

  // step divider works on one 16-bit digit at a time, in two steps: quotient digit, then remainder carry
  localparam int                   DIG_W     = 16;
  localparam int                   DIV_CNT_W = 3;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST  = DIV_CNT_W'(2 * MEM_W / DIG_W - 1);

  typedef logic [STAMP_W-1:0] stamp_t;

endpackage

// ----- rtl/epoch_stamp_reclaim_tracker.sv -----
// Path: an accepted sample passes S_LIMIT and S_CMP, then S_DONE if there is no bump; with a
// bump, S_THR0, and unless the sample is early, S_TRD and S_TCHK for each stamp reclaimed.
// S_DONE waits on out_tready while an earlier result is still held. Throughput: one item at a
// time, set by the read-modify-write on the ring memory; the next item is taken the cycle after
// the result is loaded unless the divider is busy. Reset clears the stamps and sweeps the ring,
// one slot a cycle, while the step divider runs; in_tready stays low until both finish, and again after a cfg write.
module epoch_stamp_reclaim_tracker #(
  parameter int RING_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration: freeze window length
  input  logic                          cfg_we,
  input  logic [esrt_pkg::TIME_W-1:0]   cfg_wdata,
  // tdata: now_time[62:0], zero pad[63]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [esrt_pkg::IN_W-1:0]     in_tdata,
  // tdata: current_stamp[15:0], threshold_stamp[31:16], stamp_advanced[32], zero pad[39:33]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [esrt_pkg::OUT_W-1:0]    out_tdata
);
  import esrt_pkg::*;

  localparam int HALF = RING_DEPTH / 2;
  localparam int SW   = $clog2(RING_DEPTH);
  localparam logic [SW-1:0] LAST_SLOT = SW'(RING_DEPTH - 1);
  // digit step by reciprocal: remainder bits, partial dividend, multiplier width, shift
  localparam int RB = $clog2(HALF);
  localparam int XW = RB + DIG_W;
  localparam int MW = XW + 2;
  localparam int RS = XW + RB;
  localparam logic [63:0]   RECIP   = ((64'd1 << RS) / 64'(HALF)) + 64'd1;
  localparam logic [MW-1:0] RECIP_V = RECIP[MW-1:0];
  localparam logic [XW-1:0] HALF_X  = XW'(HALF);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LIMIT, S_CMP, S_THR0, S_TRD, S_TCHK, S_DONE
  } state_t;

  state_t                 state_r;
  stamp_t                 cur_stamp_r, thr_stamp_r;
  logic [SW-1:0]          cur_slot_r, thr_slot_r, clr_addr_r;
  logic [TIME_W-1:0]      now_r, thr_time_r, frozen_r;
  logic [MEM_W-1:0]       limit_r;
  logic                   adv_r;
  logic                   out_tvalid_r;
  logic [OUT_W-1:0]       out_tdata_r;

  // divider state
  logic                   div_busy_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic [MEM_W-1:0]       div_num_r;
  logic [MEM_W-1:0]       div_q_r;
  logic [RB-1:0]          div_rem_r;
  logic [DIG_W-1:0]       div_dig_r;
  logic [XW-1:0]          div_x;
  logic [XW+MW-1:0]       div_prod;
  logic [XW-1:0]          div_back;
  logic [XW-1:0]          div_left;

  // ring memory
  logic [MEM_W-1:0]       mem [RING_DEPTH];
  logic [MEM_W-1:0]       mem_rdata_r;
  logic                   mem_we, mem_re;
  logic [SW-1:0]          mem_waddr, mem_raddr;
  logic [MEM_W-1:0]       mem_wdata;

  logic                   in_acc;
  logic                   adv;
  logic                   keep_thr;
  logic [SW-1:0]          cur_slot_inc, thr_slot_inc;
  logic [MEM_W:0]         lim_sum;
  logic [MEM_W-1:0]       thr_diff;

  // slot of stamp+1, given the slot of stamp
  function automatic logic [SW-1:0] next_slot(input stamp_t stamp, input logic [SW-1:0] slot);
    logic [SW-1:0] res;
    if (stamp == {STAMP_W{1'b1}}) begin
      res = '0;
    end else if (slot == LAST_SLOT) begin
      res = '0;
    end else begin
      res = slot + 1'b1;
    end
    return res;
  endfunction

  assign in_tready    = (state_r == S_IDLE) && !div_busy_r;
  assign in_acc       = in_tvalid && in_tready;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign cur_slot_inc = next_slot(cur_stamp_r, cur_slot_r);
  assign thr_slot_inc = next_slot(thr_stamp_r, thr_slot_r);
  assign lim_sum      = {1'b0, mem_rdata_r} + {1'b0, div_q_r};
  assign adv          = {1'b0, now_r} > limit_r;
  assign thr_diff     = {1'b0, now_r} - {1'b0, frozen_r};
  assign keep_thr     = {1'b0, thr_time_r} < mem_rdata_r;

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cur_slot_inc;
    mem_raddr = cur_slot_r;
    mem_wdata = FUTURE_TIME;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = (clr_addr_r == '0) ? '0 : FUTURE_TIME;
      end
      S_IDLE: begin
        mem_re = in_acc;
      end
      S_CMP: begin
        mem_we    = adv;
        mem_wdata = {1'b0, now_r};
      end
      S_TRD: begin
        mem_re    = (thr_stamp_r != cur_stamp_r);
        mem_raddr = thr_slot_inc;
      end
      S_TCHK: begin
        mem_we    = !keep_thr;
        mem_waddr = thr_slot_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_raddr];
    end
  end

  // step = window / half the ring depth, top digit first, each digit by reciprocal multiply
  assign div_x    = {div_rem_r, div_num_r[MEM_W-1 -: DIG_W]};
  assign div_prod = {{MW{1'b0}}, div_x} * {{XW{1'b0}}, RECIP_V};
  assign div_back = {{RB{1'b0}}, div_dig_r} * HALF_X;
  assign div_left = div_x - div_back;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r   <= FROZEN_RESET;
      div_num_r  <= {1'b0, FROZEN_RESET};
      div_rem_r  <= '0;
      div_cnt_r  <= '0;
      div_busy_r <= 1'b1;
    end else if (cfg_we) begin
      frozen_r   <= cfg_wdata;
      div_num_r  <= {1'b0, cfg_wdata};
      div_rem_r  <= '0;
      div_cnt_r  <= '0;
      div_busy_r <= 1'b1;
    end else if (div_busy_r) begin
      div_cnt_r <= div_cnt_r + 1'b1;
      if (!div_cnt_r[0]) begin
        // quotient digit
        div_dig_r <= div_prod[RS +: DIG_W];
      end else begin
        // remainder carries into the next digit
        div_rem_r <= div_left[RB-1:0];
        div_num_r <= {div_num_r[MEM_W-DIG_W-1:0], {DIG_W{1'b0}}};
        div_q_r   <= {div_q_r[MEM_W-DIG_W-1:0], div_dig_r};
      end
      if (div_cnt_r == DIV_LAST) begin
        div_busy_r <= 1'b0;
      end
    end
  end

  // item sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cur_stamp_r  <= '0;
      thr_stamp_r  <= '0;
      cur_slot_r   <= '0;
      thr_slot_r   <= '0;
      clr_addr_r   <= '0;
      adv_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_DONE)) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == LAST_SLOT) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            now_r   <= in_tdata[TIME_W-1:0];
            state_r <= S_LIMIT;
          end
        end
        S_LIMIT: begin
          // saturating start + step
          limit_r <= lim_sum[MEM_W] ? FUTURE_TIME : lim_sum[MEM_W-1:0];
          state_r <= S_CMP;
        end
        S_CMP: begin
          adv_r <= adv;
          if (adv) begin
            cur_stamp_r <= cur_stamp_r + 1'b1;
            cur_slot_r  <= cur_slot_inc;
            state_r     <= S_THR0;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_THR0: begin
          // early sample: nothing old enough to reclaim
          thr_time_r <= thr_diff[TIME_W-1:0];
          state_r    <= thr_diff[MEM_W-1] ? S_DONE : S_TRD;
        end
        S_TRD: begin
          state_r <= (thr_stamp_r == cur_stamp_r) ? S_DONE : S_TCHK;
        end
        S_TCHK: begin
          if (keep_thr) begin
            state_r <= S_DONE;
          end else begin
            thr_stamp_r <= thr_stamp_r + 1'b1;
            thr_slot_r  <= thr_slot_inc;
            state_r     <= S_TRD;
          end
        end
        S_DONE: begin
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {{(OUT_W-2*STAMP_W-1){1'b0}}, adv_r, thr_stamp_r, cur_stamp_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // slot pointers stay inside the ring
  a_cur_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_slot_r <= LAST_SLOT) else $error("cur slot out of range");

  a_thr_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    thr_slot_r <= LAST_SLOT) else $error("thr slot out of range");

  // never read and write one entry in the same cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr)) else $error("ring port collision");

  // a bump moves the current stamp by exactly one
  a_bump_by_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP && adv) |=> (cur_stamp_r == STAMP_W'($past(cur_stamp_r) + 1'b1)))
    else $error("bad stamp bump");

  // the threshold never passes the current stamp
  a_thr_behind_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TCHK && mem_we) |-> (thr_stamp_r != cur_stamp_r))
    else $error("threshold overran current stamp");

endmodule
